### design/receiver_sequence_sack_tracker_assert.svh
// Assertion macros for the receiver sequence / SACK tracker.
// Included by the top level; expects clk and rst_n in scope at the use site.
`ifndef RECEIVER_SEQUENCE_SACK_TRACKER_ASSERT_SVH
`define RECEIVER_SEQUENCE_SACK_TRACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked property check, disabled while reset is asserted.
`define RSST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsst assertion failed");
// Condition that must never hold on a clock edge.
`define RSST_ASSERT_NEVER(label, cond) `RSST_ASSERT(label, !(cond))
`else
`define RSST_ASSERT(label, prop)
`define RSST_ASSERT_NEVER(label, cond)
`endif
`endif

### design/rsst_pkg.sv
// Package for the receiver sequence / SACK tracker: beat types, codes and
// serial-number compare helpers. No dependencies.
package rsst_pkg;

    localparam int unsigned SEQ_W     = 32;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned KIND_W    = 2;

    // Request types
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_ACK  = 1'b1;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] V_ACCEPT   = 3'd0;
    localparam logic [VERDICT_W-1:0] V_OUTRANGE = 3'd1;
    localparam logic [VERDICT_W-1:0] V_DUP      = 3'd2;
    localparam logic [VERDICT_W-1:0] V_OLD      = 3'd3;
    localparam logic [VERDICT_W-1:0] V_NOTDATA  = 3'd4;

    // Emitted acknowledgement kinds
    localparam logic [KIND_W-1:0] EMIT_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EMIT_PLAIN = 2'd1;
    localparam logic [KIND_W-1:0] EMIT_SACK  = 2'd2;

    typedef logic [SEQ_W-1:0] seq_t;

    typedef struct packed {
        logic req_type;
        seq_t packet_seq;
    } req_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        seq_t                 expected_out;
        seq_t                 range_low_out;
        seq_t                 range_high_out;
        logic                 gap_open;
        logic                 ack_pending;
        logic [KIND_W-1:0]    emit_kind;
        seq_t                 hdr_seq;
        seq_t                 hdr_ack_seq;
    } rsp_t;

    // Serial a < b: forward distance from a to b is nonzero and below half circle.
    function automatic logic ser_lt(input seq_t a, input seq_t b);
        seq_t d;
        d = b - a;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

    // Serial a > b
    function automatic logic ser_gt(input seq_t a, input seq_t b);
        seq_t d;
        d = a - b;
        return (d != '0) && !d[SEQ_W-1];
    endfunction

endpackage

### design/receiver_sequence_sack_tracker.sv
// Receiver sequence / SACK tracker, top level.
// Depends on rsst_pkg.sv and receiver_sequence_sack_tracker_assert.svh.

// Tracks the receive side of a reliable transport. Each req beat is either a
// data packet (req_type REQ_DATA) with a 32-bit sequence number or an ack
// request (REQ_ACK). Sequence numbers compare with 32-bit serial arithmetic,
// so everything wraps cleanly; a number exactly half a circle from the
// frontier counts as already acked. The block holds the next expected
// number, one out-of-order range [low, high), a gap flag, an ack-pending
// flag and its own send counter. Every req beat yields exactly one rsp beat
// carrying the verdict, the state after the beat and, for ack requests, the
// emitted header (selective ack while a gap is open, plain ack otherwise,
// nothing when no ack is pending). One beat per clock while rsp_ready does not
// stall the output: the whole state update is a single combinational pass from
// the req port into the state and result registers, so back-to-back beats see
// each other's updates with no hazard. rsp_valid rises in the cycle after accept.
// The rsp register decouples the sides: req_ready stays high while the output
// is empty or being drained in the same cycle.
module receiver_sequence_sack_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  rsst_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output rsst_pkg::rsp_t  rsp
);

    `include "receiver_sequence_sack_tracker_assert.svh"

    // Tracker state
    rsst_pkg::seq_t expected_reg, expected_next;
    rsst_pkg::seq_t range_low_reg, range_low_next;
    rsst_pkg::seq_t range_high_reg, range_high_next;
    rsst_pkg::seq_t send_seq_reg, send_seq_next;
    logic           gap_reg, gap_next;
    logic           update_reg, update_next;

    // Result register
    rsst_pkg::rsp_t rsp_reg, rsp_next;
    logic           rsp_valid_reg;

    logic           acc;
    rsst_pkg::seq_t exp_inc;
    rsst_pkg::seq_t seq_inc;
    logic [rsst_pkg::VERDICT_W-1:0] verdict;
    logic [rsst_pkg::KIND_W-1:0]    kind;
    rsst_pkg::seq_t hdr_seq;
    rsst_pkg::seq_t hdr_ack;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign acc       = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign exp_inc = expected_reg + 1'b1;
    assign seq_inc = req.packet_seq + 1'b1;

    always_comb
    begin
        expected_next   = expected_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        send_seq_next   = send_seq_reg;
        gap_next        = gap_reg;
        update_next     = update_reg;
        verdict         = rsst_pkg::V_NOTDATA;
        kind            = rsst_pkg::EMIT_NONE;
        hdr_seq         = '0;
        hdr_ack         = '0;

        case (req.req_type)
            rsst_pkg::REQ_DATA:
            begin
                if (req.packet_seq == expected_reg)
                begin
                    // in order: advance, merge with the range if we reach it
                    expected_next = exp_inc;
                    if (gap_reg && (exp_inc == range_low_reg))
                    begin
                        expected_next = range_high_reg;
                        gap_next      = 1'b0;
                    end
                    update_next = 1'b1;
                    verdict     = rsst_pkg::V_ACCEPT;
                end
                else if (!rsst_pkg::ser_lt(expected_reg, req.packet_seq))
                begin
                    verdict = rsst_pkg::V_OLD;
                end
                else if (!gap_reg)
                begin
                    // open a new range
                    gap_next        = 1'b1;
                    update_next     = 1'b1;
                    range_low_next  = req.packet_seq;
                    range_high_next = seq_inc;
                    verdict         = rsst_pkg::V_ACCEPT;
                end
                else if (req.packet_seq == range_high_reg)
                begin
                    range_high_next = seq_inc;
                    update_next     = 1'b1;
                    verdict         = rsst_pkg::V_ACCEPT;
                end
                else if (seq_inc == range_low_reg)
                begin
                    // extend down; merge if it touches the frontier
                    range_low_next = req.packet_seq;
                    if (req.packet_seq == expected_reg)
                    begin
                        expected_next = range_high_reg;
                        gap_next      = 1'b0;
                    end
                    update_next = 1'b1;
                    verdict     = rsst_pkg::V_ACCEPT;
                end
                else if (rsst_pkg::ser_lt(req.packet_seq, range_low_reg) ||
                         rsst_pkg::ser_gt(req.packet_seq, range_high_reg))
                begin
                    verdict = rsst_pkg::V_OUTRANGE;
                end
                else
                begin
                    verdict = rsst_pkg::V_DUP;
                end
            end
            default:
            begin
                if (update_reg)
                begin
                    if (gap_reg)
                    begin
                        kind    = rsst_pkg::EMIT_SACK;
                        hdr_seq = range_low_reg;
                        hdr_ack = range_high_reg;
                    end
                    else
                    begin
                        kind          = rsst_pkg::EMIT_PLAIN;
                        hdr_seq       = send_seq_reg;
                        send_seq_next = send_seq_reg + 1'b1;
                        hdr_ack       = expected_reg;
                    end
                    update_next = 1'b0;
                end
            end
        endcase

        rsp_next.verdict        = verdict;
        rsp_next.expected_out   = expected_next;
        rsp_next.range_low_out  = range_low_next;
        rsp_next.range_high_out = range_high_next;
        rsp_next.gap_open       = gap_next;
        rsp_next.ack_pending    = update_next;
        rsp_next.emit_kind      = kind;
        rsp_next.hdr_seq        = hdr_seq;
        rsp_next.hdr_ack_seq    = hdr_ack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg   <= '0;
            range_low_reg  <= '0;
            range_high_reg <= '0;
            send_seq_reg   <= '0;
            gap_reg        <= 1'b0;
            update_reg     <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                expected_reg   <= expected_next;
                range_low_reg  <= range_low_next;
                range_high_reg <= range_high_next;
                send_seq_reg   <= send_seq_next;
                gap_reg        <= gap_next;
                update_reg     <= update_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // State moves only on an accepted beat
    `RSST_ASSERT(a_state_hold, !acc |=> ($stable(expected_reg) && $stable(send_seq_reg) && $stable(gap_reg) && $stable(update_reg)))
    // An accepted packet always leaves an ack pending
    `RSST_ASSERT(a_accept_pending, (acc && (req.req_type == rsst_pkg::REQ_DATA) && (verdict == rsst_pkg::V_ACCEPT)) |=> update_reg)
    // An ack request always clears the pending flag
    `RSST_ASSERT(a_ack_clears, (acc && (req.req_type == rsst_pkg::REQ_ACK)) |=> !update_reg)
    // Send counter only moves on a plain ack
    `RSST_ASSERT_NEVER(a_send_cnt, acc && (kind != rsst_pkg::EMIT_PLAIN) && (send_seq_next != send_seq_reg))

endmodule

### test/receiver_sequence_sack_tracker_tb.sv
// Self-checking testbench for receiver_sequence_sack_tracker: directed and random beats
// with random idling on both channels, each result checked against a built-in predictor.
// Depends on rsst_pkg.sv and the design top level.
module receiver_sequence_sack_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BEATS = 1650;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int unsigned QUIET_LIMIT  = 500;
    // Settle time after the last result.
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam rsst_pkg::seq_t HALF_CIRCLE = 32'h8000_0000;

    // Receive-window predictor plus the queue of results it still expects.
    class rx_window_model;
        rsst_pkg::seq_t exp_next  = '0;
        rsst_pkg::seq_t rng_lo    = '0;
        rsst_pkg::seq_t rng_hi    = '0;
        bit             gap       = 1'b0;
        bit             pend      = 1'b0;
        rsst_pkg::seq_t own_ctr   = '0;
        int             failures  = 0;
        rsst_pkg::rsp_t pending_status[$];

        // True when b lies strictly ahead of a on the 32-bit serial circle.
        function bit ahead_of(rsst_pkg::seq_t a, rsst_pkg::seq_t b);
            rsst_pkg::seq_t d;
            d = b - a;
            return (d != '0) && (d < HALF_CIRCLE);
        endfunction

        function logic [rsst_pkg::VERDICT_W-1:0] take_data(rsst_pkg::seq_t s);
            if (s == exp_next) begin
                exp_next = exp_next + 1;
                // frontier ran into the tracked range: jump over it
                if (gap && exp_next == rng_lo) begin
                    exp_next = rng_hi;
                    gap      = 1'b0;
                end
                pend = 1'b1;
                return rsst_pkg::V_ACCEPT;
            end
            // behind the frontier, or exactly half a circle away
            if (!ahead_of(exp_next, s))
                return rsst_pkg::V_OLD;
            if (!gap) begin
                gap    = 1'b1;
                pend   = 1'b1;
                rng_lo = s;
                rng_hi = s + 1;
                return rsst_pkg::V_ACCEPT;
            end
            if (s == rng_hi) begin
                rng_hi = s + 1;
                pend   = 1'b1;
                return rsst_pkg::V_ACCEPT;
            end
            if (rsst_pkg::seq_t'(s + 1) == rng_lo) begin
                rng_lo = s;
                if (rng_lo == exp_next) begin
                    exp_next = rng_hi;
                    gap      = 1'b0;
                end
                pend = 1'b1;
                return rsst_pkg::V_ACCEPT;
            end
            if (ahead_of(s, rng_lo) || ahead_of(rng_hi, s))
                return rsst_pkg::V_OUTRANGE;
            return rsst_pkg::V_DUP;
        endfunction

        function void note_request(rsst_pkg::req_t r);
            rsst_pkg::rsp_t p;
            p = '0;
            if (r.req_type == rsst_pkg::REQ_DATA) begin
                p.verdict = take_data(r.packet_seq);
            end
            else begin
                p.verdict   = rsst_pkg::V_NOTDATA;
                p.emit_kind = rsst_pkg::EMIT_NONE;
                if (pend) begin
                    if (gap) begin
                        p.emit_kind   = rsst_pkg::EMIT_SACK;
                        p.hdr_seq     = rng_lo;
                        p.hdr_ack_seq = rng_hi;
                    end
                    else begin
                        p.emit_kind   = rsst_pkg::EMIT_PLAIN;
                        p.hdr_seq     = own_ctr;
                        own_ctr       = own_ctr + 1;
                        p.hdr_ack_seq = exp_next;
                    end
                    pend = 1'b0;
                end
            end
            p.expected_out   = exp_next;
            p.range_low_out  = rng_lo;
            p.range_high_out = rng_hi;
            p.gap_open       = gap;
            p.ack_pending    = pend;
            pending_status.push_back(p);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(rsst_pkg::rsp_t got);
            rsst_pkg::rsp_t want;
            if (pending_status.size() == 0) begin
                $error("result beat with no expectation waiting");
                failures++;
                return;
            end
            want = pending_status.pop_front();
            compare_field("verdict",        32'(want.verdict),     32'(got.verdict));
            compare_field("expected_out",   want.expected_out,     got.expected_out);
            compare_field("range_low_out",  want.range_low_out,    got.range_low_out);
            compare_field("range_high_out", want.range_high_out,   got.range_high_out);
            compare_field("gap_open",       32'(want.gap_open),    32'(got.gap_open));
            compare_field("ack_pending",    32'(want.ack_pending), 32'(got.ack_pending));
            compare_field("emit_kind",      32'(want.emit_kind),   32'(got.emit_kind));
            compare_field("hdr_seq",        want.hdr_seq,          got.hdr_seq);
            compare_field("hdr_ack_seq",    want.hdr_ack_seq,      got.hdr_ack_seq);
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    rsst_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    rsst_pkg::rsp_t rsp;

    rx_window_model model = new;
    int unsigned tx_count = 0;
    int unsigned rx_count = 0;
    int unsigned quiet    = 0;

    receiver_sequence_sack_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // Drive one request beat. Called at a rising edge; returns at the edge that
    // accepts the beat, after the predictor has seen it, so the caller can pick
    // the next beat from the updated window state.
    task automatic send_request(rsst_pkg::req_t r);
        int unsigned gap_cycles;
        // every 200 beats, a 40-beat stretch with valid held high back to back
        gap_cycles = ((tx_count % 200) < 40) ? 0 : $urandom_range(0, 11);
        tx_count++;
        if (gap_cycles > 0) begin
            req_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        model.note_request(r);
    endtask

    task automatic send_data(rsst_pkg::seq_t s);
        rsst_pkg::req_t r;
        r.req_type   = rsst_pkg::REQ_DATA;
        r.packet_seq = s;
        send_request(r);
    endtask

    task automatic send_ack(rsst_pkg::seq_t junk);
        rsst_pkg::req_t r;
        r.req_type   = rsst_pkg::REQ_ACK;
        r.packet_seq = junk;
        send_request(r);
    endtask

    // Random beat aimed at the current window: mostly in-order packets, range
    // edges and ack requests, with a share of stale, half-circle and noise packets.
    // Wild numbers are only sent while a range is open, so a range far from the
    // frontier (which would never close in a short run) is not opened.
    function automatic rsst_pkg::req_t next_random_request();
        rsst_pkg::req_t r;
        int unsigned    pick;
        rsst_pkg::seq_t span;
        rsst_pkg::seq_t noise;
        r.req_type   = rsst_pkg::REQ_DATA;
        r.packet_seq = model.exp_next;
        pick         = $urandom_range(0, 99);
        noise        = $urandom();
        if (pick < 18) begin
            r.req_type   = rsst_pkg::REQ_ACK;
            r.packet_seq = noise;
        end
        else if (pick < 42)
            r.packet_seq = model.exp_next;
        else if (pick < 56)
            r.packet_seq = model.exp_next + $urandom_range(1, 6);
        else if (pick < 66)
            r.packet_seq = model.rng_hi + $urandom_range(0, 2);
        else if (pick < 74)
            r.packet_seq = model.rng_lo - $urandom_range(1, 3);
        else if (pick < 80) begin
            span = model.rng_hi - model.rng_lo;
            r.packet_seq = model.rng_lo + ((span == '0) ? '0 : (noise % span));
        end
        else if (pick < 86)
            r.packet_seq = model.exp_next - $urandom_range(1, 40);
        else if (pick < 92)
            r.packet_seq = model.exp_next + HALF_CIRCLE + $urandom_range(0, 1);
        else if (model.gap)
            r.packet_seq = noise;
        else
            // somewhere in the back half of the circle: always stale
            r.packet_seq = model.exp_next + {1'b1, noise[30:0]};
        return r;
    endfunction

    // Result side: stall a random number of cycles per beat, then take it and check.
    initial begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = ((rx_count % 150) < 30) ? 0 : $urandom_range(0, 11);
            rx_count++;
            if (stall > 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            model.check_result(rsp);
        end
    end

    // Watchdog: a long stretch with no beat on either channel means a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Comments give the window state after each beat.
        send_ack(32'hFFFF_FFFF);     // nothing pending after reset: no emit
        send_data(32'd0);            // in order, E=1
        send_ack(32'h0000_0000);     // plain ack, own counter 0
        send_ack(32'h5A5A_A5A5);     // nothing pending: no emit
        send_data(32'd0);            // already acked
        send_data(32'hFFFF_FFFF);    // behind across the wrap: already acked
        send_data(32'h8000_0001);    // exactly half a circle ahead: already acked
        send_data(32'd5);            // opens range [5,6)
        send_data(32'd6);            // extends up [5,7)
        send_data(32'd7);            // extends up [5,8)
        send_ack(32'h1234_5678);     // selective ack 5..8
        send_data(32'd4);            // extends down [4,8)
        send_data(32'd6);            // duplicate inside the range
        send_data(32'd20);           // beyond the range
        send_data(32'd2);            // ahead of E but below the range
        send_data(32'd1);            // in order, E=2
        send_data(32'd3);            // extends down [3,8)
        send_data(32'd2);            // frontier meets range: merge, E=8
        send_ack(32'h8000_0000);     // plain ack, own counter 1
        send_data(32'd10);           // opens [10,11)
        send_data(32'd9);            // extends down [9,11)
        send_data(32'd8);            // in order into the range: merge, E=11
        send_data(32'h8000_000B);    // half circle from E=11
        send_ack(32'hFFFF_FFFF);     // plain ack, own counter 2

        repeat (RANDOM_BEATS)
            send_request(next_random_request());
        req_valid <= 1'b0;

        while (model.pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (model.failures == 0 && model.pending_status.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/rsst_pkg.sv
design/receiver_sequence_sack_tracker.sv
test/receiver_sequence_sack_tracker_tb.sv
